// File: design/stable_merge_sort_by_length_assert.svh
// Assertion macros shared by the sort block.
`ifndef STABLE_MERGE_SORT_BY_LENGTH_ASSERT_SVH
`define STABLE_MERGE_SORT_BY_LENGTH_ASSERT_SVH

// The condition must never be seen at a clock edge outside reset.
`define SMSL_ASSERT_NEVER(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("smsl: forbidden condition seen");

// The antecedent at one edge requires the consequent at the next edge.
`define SMSL_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smsl: expected condition missing one cycle later");

`endif

// File: design/smsl_pkg.sv
`default_nettype none

package smsl_pkg;

   // Default sizes of the block.
   localparam int MAX_WORDS_DEF = 64;
   localparam int LEN_WIDTH_DEF = 8;

   // Fixed widths of the channel fields.
   localparam int WORD_LEN_W   = 8;
   localparam int WORD_INDEX_W = 6;
   localparam int SORTED_LEN_W = 8;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PASS,
      ST_SEG,
      ST_RDL,
      ST_RDR,
      ST_FILL,
      ST_MERGE,
      ST_ORD,
      ST_OCAP,
      ST_OHOLD
   } state_type;

   // Write enables of the two key memories.
   typedef struct packed {
      logic key_we;
      logic scratch_we;
   } ram_we_type;

endpackage

`default_nettype wire

// File: design/smsl_req_if.sv
`default_nettype none

interface smsl_req_if;
   import smsl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [WORD_LEN_W-1:0] word_len;
   logic                  last;

   modport source (output valid, output word_len, output last, input ready);
   modport sink (input valid, input word_len, input last, output ready);
endinterface

`default_nettype wire

// File: design/smsl_rsp_if.sv
`default_nettype none

interface smsl_rsp_if;
   import smsl_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [WORD_INDEX_W-1:0] word_index;
   logic [SORTED_LEN_W-1:0] sorted_len;
   logic                    overflow;
   logic                    last_out;

   modport source (output valid, output word_index, output sorted_len,
                   output overflow, output last_out, input ready);
   modport sink (input valid, input word_index, input sorted_len,
                 input overflow, input last_out, output ready);
endinterface

`default_nettype wire

// File: design/smsl_ram.sv
`default_nettype none

module smsl_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: design/smsl_sorter.sv
`default_nettype none

module smsl_sorter #(
   parameter int MAX_WORDS = smsl_pkg::MAX_WORDS_DEF,
   parameter int LEN_WIDTH = smsl_pkg::LEN_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   smsl_req_if.sink                                req_ch,
   smsl_rsp_if.source                              rsp_ch,
   output smsl_pkg::ram_we_type                    ram_we,
   output logic [$clog2(MAX_WORDS)-1:0]            ram_waddr,
   output logic [LEN_WIDTH+$clog2(MAX_WORDS)-1:0]  ram_wdata,
   output logic [$clog2(MAX_WORDS)-1:0]            ram_raddr,
   input  logic [LEN_WIDTH+$clog2(MAX_WORDS)-1:0]  key_rdata,
   input  logic [LEN_WIDTH+$clog2(MAX_WORDS)-1:0]  scratch_rdata
);
   import smsl_pkg::*;

   localparam int IDX_W = $clog2(MAX_WORDS);
   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam int WID_W = CNT_W + 1;
   localparam int SUM_W = WID_W + 1;
   localparam int KEY_W = LEN_WIDTH + IDX_W;
   localparam int SAT_W = (LEN_WIDTH > WORD_LEN_W) ? LEN_WIDTH : WORD_LEN_W;
   localparam logic [SAT_W-1:0] LEN_MAX = SAT_W'((1 << LEN_WIDTH) - 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [WID_W-1:0] width_ff, width_in;
   logic             src_ff, src_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             fill_right_ff, fill_right_in;
   logic [KEY_W-1:0] hl_ff, hl_in;
   logic [KEY_W-1:0] hr_ff, hr_in;

   logic [WORD_INDEX_W-1:0] word_index_ff, word_index_in;
   logic [SORTED_LEN_W-1:0] sorted_len_ff, sorted_len_in;
   logic                    last_out_ff, last_out_in;

   logic             accept_in;
   logic             accept_out;
   logic             full;
   logic [SAT_W-1:0] len_wide;
   logic [SAT_W-1:0] len_sat;
   logic [KEY_W-1:0] load_key;
   logic [KEY_W-1:0] rdata_src;
   logic [SAT_W-1:0] len_rd_wide;
   logic             take_left;
   logic [KEY_W-1:0] merge_key;
   logic [SUM_W-1:0] lo_w;
   logic [SUM_W-1:0] lo_2w;
   logic [SUM_W-1:0] n_wide;
   logic [CNT_W-1:0] seg_mid;
   logic [CNT_W-1:0] seg_hi;
   logic             seg_done;
   logic             pass_done;
   logic [CNT_W-1:0] k_next;
   logic             merge_end;
   logic             out_last;

   // Handshakes and capacity.
   assign accept_in  = req_ch.valid && req_ch.ready;
   assign accept_out = rsp_ch.valid && rsp_ch.ready;
   assign full       = (count_ff == CNT_W'(MAX_WORDS));

   // Length saturation and the key of an arriving word: length above, index below.
   assign len_wide = SAT_W'(req_ch.word_len);
   assign len_sat  = (len_wide > LEN_MAX) ? LEN_MAX : len_wide;
   assign load_key = {len_sat[LEN_WIDTH-1:0], count_ff[IDX_W-1:0]};

   // The memory holding the current run layout.
   assign rdata_src   = src_ff ? scratch_rdata : key_rdata;
   assign len_rd_wide = SAT_W'(rdata_src[KEY_W-1 -: LEN_WIDTH]);

   // Shared compare unit. Keys are unique, so an unsigned key compare orders by
   // length and then by arrival index; an exhausted run never wins.
   assign take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (hl_ff < hr_ff));
   assign merge_key = take_left ? hl_ff : hr_ff;

   // Segment bounds for the next pair of runs, clipped to the word count.
   assign lo_w      = SUM_W'(lo_ff) + SUM_W'(width_ff);
   assign lo_2w     = lo_w + SUM_W'(width_ff);
   assign n_wide    = SUM_W'(count_ff);
   assign seg_mid   = (lo_w > n_wide) ? count_ff : CNT_W'(lo_w);
   assign seg_hi    = (lo_2w > n_wide) ? count_ff : CNT_W'(lo_2w);
   assign seg_done  = (lo_ff >= count_ff);
   assign pass_done = (WID_W'(count_ff) <= width_ff);

   assign k_next    = k_ff + CNT_W'(1);
   assign merge_end = (k_next == hi_ff);
   assign out_last  = (k_next == count_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept_in && req_ch.last) begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            state_in = pass_done ? ST_ORD : ST_SEG;
         end
         ST_SEG: begin
            state_in = seg_done ? ST_PASS : ST_RDL;
         end
         ST_RDL: begin
            state_in = ST_RDR;
         end
         ST_RDR: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            state_in = merge_end ? ST_SEG : ST_FILL;
         end
         ST_ORD: begin
            state_in = ST_OCAP;
         end
         ST_OCAP: begin
            state_in = ST_OHOLD;
         end
         ST_OHOLD: begin
            if (accept_out) begin
               state_in = last_out_ff ? ST_LOAD : ST_OCAP;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Handshake and memory port outputs.
   always_comb begin
      req_ch.ready      = 1'b0;
      rsp_ch.valid      = 1'b0;
      ram_we.key_we     = 1'b0;
      ram_we.scratch_we = 1'b0;
      ram_waddr         = k_ff[IDX_W-1:0];
      ram_wdata         = merge_key;
      ram_raddr         = k_ff[IDX_W-1:0];
      case (state_ff)
         ST_LOAD: begin
            req_ch.ready  = 1'b1;
            ram_we.key_we = accept_in && !full;
            ram_waddr     = count_ff[IDX_W-1:0];
            ram_wdata     = load_key;
         end
         ST_RDL: begin
            ram_raddr = i_ff[IDX_W-1:0];
         end
         ST_RDR: begin
            ram_raddr = j_ff[IDX_W-1:0];
         end
         ST_MERGE: begin
            // Write the winner to the other memory and fetch its successor.
            ram_we.key_we     = src_ff;
            ram_we.scratch_we = !src_ff;
            if (take_left) begin
               ram_raddr = i_ff[IDX_W-1:0] + IDX_W'(1);
            end else begin
               ram_raddr = j_ff[IDX_W-1:0] + IDX_W'(1);
            end
         end
         ST_OHOLD: begin
            rsp_ch.valid = 1'b1;
            ram_raddr    = k_next[IDX_W-1:0];
         end
         default: begin
            ram_raddr = k_ff[IDX_W-1:0];
         end
      endcase
   end

   // Counters, run bounds and head registers.
   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      width_in      = width_ff;
      src_in        = src_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      hi_in         = hi_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      fill_right_in = fill_right_ff;
      hl_in         = hl_ff;
      hr_in         = hr_ff;
      word_index_in = word_index_ff;
      sorted_len_in = sorted_len_ff;
      last_out_in   = last_out_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept_in) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               width_in = WID_W'(1);
               src_in   = 1'b0;
               lo_in    = '0;
            end
         end
         ST_PASS: begin
            lo_in = '0;
            k_in  = '0;
         end
         ST_SEG: begin
            if (seg_done) begin
               width_in = width_ff << 1;
               src_in   = !src_ff;
            end else begin
               mid_in = seg_mid;
               hi_in  = seg_hi;
               i_in   = lo_ff;
               j_in   = seg_mid;
               k_in   = lo_ff;
            end
         end
         ST_RDR: begin
            hl_in         = rdata_src;
            fill_right_in = 1'b1;
         end
         ST_FILL: begin
            if (fill_right_ff) begin
               hr_in = rdata_src;
            end else begin
               hl_in = rdata_src;
            end
         end
         ST_MERGE: begin
            k_in = k_next;
            if (take_left) begin
               i_in          = i_ff + CNT_W'(1);
               fill_right_in = 1'b0;
            end else begin
               j_in          = j_ff + CNT_W'(1);
               fill_right_in = 1'b1;
            end
            if (merge_end) begin
               lo_in = hi_ff;
            end
         end
         ST_OCAP: begin
            word_index_in = WORD_INDEX_W'(rdata_src[IDX_W-1:0]);
            sorted_len_in = len_rd_wide[SORTED_LEN_W-1:0];
            last_out_in   = out_last;
         end
         ST_OHOLD: begin
            if (accept_out) begin
               if (last_out_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  k_in = k_next;
               end
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      width_ff      <= width_in;
      src_ff        <= src_in;
      lo_ff         <= lo_in;
      mid_ff        <= mid_in;
      hi_ff         <= hi_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      fill_right_ff <= fill_right_in;
      hl_ff         <= hl_in;
      hr_ff         <= hr_in;
      word_index_ff <= word_index_in;
      sorted_len_ff <= sorted_len_in;
      last_out_ff   <= last_out_in;
   end

   // Result beat fields come straight from registers.
   assign rsp_ch.word_index = word_index_ff;
   assign rsp_ch.sorted_len = sorted_len_ff;
   assign rsp_ch.overflow   = ovf_ff;
   assign rsp_ch.last_out   = last_out_ff;

endmodule

`default_nettype wire

// File: design/stable_merge_sort_by_length.sv
`default_nettype none

// Channel   Direction  Beat contents
// req_ch    in         word_len, last
// rsp_ch    out        word_index, sorted_len, overflow, last_out
//
// A word is taken whenever req_ch.ready is high in the load state; a list of n words
// then sorts in ceil(log2 n) merge passes. The single compare unit moves one key at a
// time through the memory read port, each key passing the FILL and MERGE states in turn.
// ORD opens the result stream; each result beat is then fetched in OCAP and held in OHOLD.
// Reset is synchronous and clears the sequencer, word count and overflow flag.
// req_ch.ready is low from the last word until the last result beat is taken.

module stable_merge_sort_by_length #(
   parameter int MAX_WORDS = smsl_pkg::MAX_WORDS_DEF,
   parameter int LEN_WIDTH = smsl_pkg::LEN_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   smsl_req_if.sink   req_ch,
   smsl_rsp_if.source rsp_ch
);
   import smsl_pkg::*;

   localparam int IDX_W = $clog2(MAX_WORDS);
   localparam int KEY_W = LEN_WIDTH + IDX_W;

   ram_we_type       ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [KEY_W-1:0] ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [KEY_W-1:0] key_rdata;
   logic [KEY_W-1:0] scratch_rdata;

   // Sequencer with the shared compare unit.
   smsl_sorter #(
      .MAX_WORDS (MAX_WORDS),
      .LEN_WIDTH (LEN_WIDTH)
   ) u_sorter (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .key_rdata     (key_rdata),
      .scratch_rdata (scratch_rdata)
   );

   // Key store: loaded with arriving words, then one side of each merge pass.
   smsl_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_WORDS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we.key_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (key_rdata)
   );

   // Merge scratch: the other side of each merge pass.
   smsl_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_WORDS)
   ) u_scratch_ram (
      .clock   (clock),
      .wr_en   (ram_we.scratch_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (scratch_rdata)
   );

   // Checks on the sequencing.
   `include "stable_merge_sort_by_length_assert.svh"

   `SMSL_ASSERT_NEVER(a_no_overlap, rsp_ch.valid && req_ch.ready)
   `SMSL_ASSERT_NEVER(a_one_writer, ram_we.key_we && ram_we.scratch_we)
   `SMSL_ASSERT_NEXT(a_ready_after_run,
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last_out, req_ch.ready)
   `SMSL_ASSERT_NEXT(a_busy_after_last,
      req_ch.valid && req_ch.ready && req_ch.last, !req_ch.ready)

endmodule

`default_nettype wire

// File: dv/smsl_sort_checker.sv
`timescale 1ns / 100ps

module smsl_sort_checker (
   input  logic clock,
   input  logic reset,
   smsl_req_if  req_ch,
   smsl_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending
);
   import smsl_pkg::*;

   localparam int CAPACITY = MAX_WORDS_DEF;
   localparam int LEN_MAX  = (1 << LEN_WIDTH_DEF) - 1;

   // One stored word: its clipped length and its arrival position.
   typedef struct packed {
      logic [SORTED_LEN_W-1:0] len;
      logic [WORD_INDEX_W-1:0] idx;
   } word_key_type;

   // One result beat as the block should present it.
   typedef struct packed {
      logic [WORD_INDEX_W-1:0] word_index;
      logic [SORTED_LEN_W-1:0] sorted_len;
      logic                    overflow;
      logic                    last_out;
   } sorted_beat_type;

   word_key_type    list_keys[$];
   logic            list_overflow = 1'b0;
   sorted_beat_type sorted_expect[$];
   int              errors = 0;

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      word_key_type    key;
      word_key_type    held;
      sorted_beat_type got;
      sorted_beat_type want;
      sorted_beat_type beat;
      int              pos;
      int              len_in;
      if (reset) begin
         list_keys.delete();
         sorted_expect.delete();
         list_overflow = 1'b0;
      end else begin
         // Compare each result beat with the oldest expected one.
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.word_index, rsp_ch.sorted_len, rsp_ch.overflow, rsp_ch.last_out};
            if (sorted_expect.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, actual index %0d len %0d ovf %0b last %0b",
                        $time, got.word_index, got.sorted_len, got.overflow, got.last_out);
            end else begin
               want = sorted_expect.pop_front();
               check_field("word_index", int'(want.word_index), int'(got.word_index));
               check_field("sorted_len", int'(want.sorted_len), int'(got.sorted_len));
               check_field("overflow", int'(want.overflow), int'(got.overflow));
               check_field("last_out", int'(want.last_out), int'(got.last_out));
            end
         end

         // Collect word beats; words past capacity only raise the overflow flag.
         if (req_ch.valid && req_ch.ready) begin
            len_in = (int'(req_ch.word_len) > LEN_MAX) ? LEN_MAX : int'(req_ch.word_len);
            if (list_keys.size() < CAPACITY) begin
               key.len = SORTED_LEN_W'(len_in);
               key.idx = WORD_INDEX_W'(list_keys.size());
               list_keys.insert(list_keys.size(), key);
            end else begin
               list_overflow = 1'b1;
            end

            // At the end of a list, order the words and queue the result beats.
            if (req_ch.last) begin
               // Insertion sort on length alone: arrival order already is index
               // order, and equal lengths never pass each other.
               for (int i = 1; i < list_keys.size(); i++) begin
                  held = list_keys[i];
                  pos  = i;
                  while (pos > 0 && list_keys[pos-1].len > held.len) begin
                     list_keys[pos] = list_keys[pos-1];
                     pos--;
                  end
                  list_keys[pos] = held;
               end
               foreach (list_keys[i]) begin
                  beat.word_index = list_keys[i].idx;
                  beat.sorted_len = list_keys[i].len;
                  beat.overflow   = list_overflow;
                  beat.last_out   = (i == list_keys.size() - 1);
                  sorted_expect.insert(sorted_expect.size(), beat);
               end
               list_keys.delete();
               list_overflow = 1'b0;
            end
         end
      end
      fail_count <= errors;
      pending    <= sorted_expect.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import smsl_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int DIR_WORDS   = 18;
   localparam int ITEM_TOTAL  = 220;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   burst_left = 0;
   int   words_sent = 0;
   bit   hold_arm   = 1'b0;
   bit   hold_done  = 1'b0;

   // Directed lists: single shortest word, single longest word, a mixed list
   // full of ties and extremes, a descending list, and all-equal lengths.
   logic [WORD_LEN_W-1:0] dir_len [DIR_WORDS] = '{
      8'd0,
      8'd255,
      8'd255, 8'd0, 8'd7, 8'd7, 8'd255, 8'd0, 8'd128, 8'd7,
      8'd200, 8'd150, 8'd100, 8'd50, 8'd1,
      8'd42, 8'd42, 8'd42
   };
   bit dir_last [DIR_WORDS] = '{
      1'b1,
      1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b1
   };

   smsl_req_if req_ch ();
   smsl_rsp_if rsp_ch ();

   stable_merge_sort_by_length u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   smsl_sort_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("stable_merge_sort_by_length: mismatch");
      $finish;
   end

   // Offer one word beat, with a random gap first whenever a burst runs out.
   task automatic send_word(input logic [WORD_LEN_W-1:0] len, input logic lst);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid    = 1'b0;
            req_ch.word_len = WORD_LEN_W'($urandom);
            req_ch.last     = 1'($urandom);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid    = 1'b1;
      req_ch.word_len = len;
      req_ch.last     = lst;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   // Receiver: stretches of steady, random and patterned stalls, plus one long
   // hold-off while results are waiting.
   initial begin : receiver
      int mode;
      int span;
      int tick;
      tick = 0;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            tick++;
            if (hold_arm && !hold_done && rsp_ch.valid) begin
               rsp_ch.ready = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0: begin
                  rsp_ch.ready = 1'b1;
               end
               1: begin
                  rsp_ch.ready = ($urandom_range(0, 2) != 0);
               end
               default: begin
                  rsp_ch.ready = (tick % 5) < 3;
               end
            endcase
         end
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int list_no;
      int n;
      logic [WORD_LEN_W-1:0] len;
      req_ch.valid    = 1'b0;
      req_ch.word_len = '0;
      req_ch.last     = 1'b0;
      rsp_ch.ready    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lists.
      for (int i = 0; i < DIR_WORDS; i++)
         send_word(dir_len[i], dir_last[i]);

      // Random lists, mostly short, with one exactly full list and one that
      // overflows and ends on a dropped word. Long random lists come only after
      // those two, and the final list is cut short to land on the item total.
      hold_arm = 1'b1;
      list_no  = 0;
      while (words_sent < ITEM_TOTAL) begin
         if (list_no == 1)
            n = 64;
         else if (list_no == 3)
            n = 67;
         else if (list_no > 3 && $urandom_range(0, 9) == 0)
            n = $urandom_range(60, 70);
         else
            n = $urandom_range(1, 10);
         if (list_no > 3 && n > ITEM_TOTAL - words_sent)
            n = ITEM_TOTAL - words_sent;
         for (int i = 0; i < n; i++) begin
            // Small lengths now and then to make ties common.
            len = ($urandom_range(0, 2) == 0) ? WORD_LEN_W'($urandom_range(0, 3))
                                              : WORD_LEN_W'($urandom_range(0, 255));
            send_word(len, i == n - 1);
         end
         list_no++;
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("stable_merge_sort_by_length: match");
      else
         $display("stable_merge_sort_by_length: mismatch");
      $finish;
   end

endmodule
